[rtl/window_sum_3x3_assert.svh]
// assertion macros shared by the window sum checker
`ifndef WINDOW_SUM_3X3_ASSERT_SVH
`define WINDOW_SUM_3X3_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define WS3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define WS3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ws3_pkg.sv]
// shared types and constants of the 3x3 window sum block
package ws3_pkg;

	// fixed result field widths and row limit
	localparam int SUM_BITS  = 12;
	localparam int ROW_BITS  = 10;
	localparam int ROW_LIMIT = 1024;

	// configuration register widths and reset values
	localparam int RW_BITS = 7;
	localparam int FR_BITS = 11;
	localparam logic [RW_BITS-1:0] ROW_WIDTH_RST  = 7'd5;
	localparam logic [FR_BITS-1:0] FRAME_ROWS_RST = 11'd5;

	// configuration register index
	typedef enum logic {
		REG_ROW_WIDTH  = 1'b0,
		REG_FRAME_ROWS = 1'b1
	} cfg_idx_t;

endpackage

[rtl/ws3_ram.sv]
// generic single-write, single-read ram with registered read data
module ws3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/window_sum_3x3.sv]
// 3x3 sliding window sum over a raster stream of signed samples
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_ready | sample
//  out     | out_valid/out_ready | window_sum, window_row, window_col, last_of_frame
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one request per cycle while no stalled result holds the sum stage; a sample and
// its line buffer ram read (registered) feed the sum stage, which loads the
// result register. the ram is written at the same column when the sum stage moves on.
// arst_n clears counters, window columns and handshake state and loads the configuration reset values.
// a stalled result blocks the sum stage only when that stage holds a window.
module window_sum_3x3 #(
	parameter int MAX_COLS     = 64,
	parameter int WINDOW       = 3,
	parameter int SAMPLE_WIDTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample stream
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	// window results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ws3_pkg::SUM_BITS-1:0] window_sum,
	output logic [ws3_pkg::ROW_BITS-1:0]  window_row,
	output logic [$clog2(MAX_COLS)-1:0]   window_col,
	output logic                          last_of_frame,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  ws3_pkg::cfg_idx_t             cfg_index,
	input  logic [ws3_pkg::FR_BITS-1:0]   cfg_data
);

	import ws3_pkg::*;

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int SW    = SAMPLE_WIDTH;
	localparam int LB_W  = (WINDOW - 1) * SW;
	localparam int ACC_W = SW + SUM_BITS;
	localparam int CMP_W = (COL_W + 1 > RW_BITS) ? COL_W + 1 : RW_BITS;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

	// configuration registers
	logic [RW_BITS-1:0] row_width_q;
	logic [FR_BITS-1:0] frame_rows_q;

	// raster position
	logic [COL_W-1:0]    col_count_q;
	logic [ROW_BITS-1:0] row_count_q;
	logic [COL_W-1:0]    col_cur;
	logic [CMP_W-1:0]    w_eff;
	logic [FR_BITS-1:0]  h_eff;
	logic                row_end;
	logic                frame_end;
	logic                win_now;

	// sum stage
	logic                valid_s1;
	logic                win_s1;
	logic                last_s1;
	logic signed [SW-1:0] sample_s1;
	logic [COL_W-1:0]    col_s1;
	logic [ROW_BITS-1:0] wrow_s1;
	logic [COL_W-1:0]    wcol_s1;

	// line buffer ram
	logic [LB_W-1:0] lb_rdata;
	logic [LB_W-1:0] lb_wdata;

	// window columns and sum
	logic signed [SW-1:0] wcols_q [WINDOW-1][WINDOW];
	logic signed [SW-1:0] col_now [WINDOW];
	logic signed [ACC_W-1:0] acc;

	// result register
	logic                       out_valid_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [ROW_BITS-1:0]        row_q;
	logic [COL_W-1:0]           col_q;
	logic                       last_q;

	logic in_fire;
	logic s1_go;
	logic s2_free;

	// handshake
	assign s2_free   = !out_valid_q || out_ready;
	assign s1_go     = valid_s1 && (!win_s1 || s2_free);
	assign in_ready  = !valid_s1 || s1_go;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= ROW_WIDTH_RST;
			frame_rows_q <= FRAME_ROWS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_WIDTH:  row_width_q  <= cfg_data[RW_BITS-1:0];
				REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame size and position of the incoming sample
	always_comb begin
		col_cur = (col_count_q > COL_LAST) ? COL_LAST : col_count_q;
		w_eff   = CMP_W'(row_width_q);
		if (w_eff < CMP_W'(WINDOW)) begin
			w_eff = CMP_W'(WINDOW);
		end else if (w_eff > CMP_W'(MAX_COLS)) begin
			w_eff = CMP_W'(MAX_COLS);
		end
		h_eff = frame_rows_q;
		if (h_eff < FR_BITS'(WINDOW)) begin
			h_eff = FR_BITS'(WINDOW);
		end else if (h_eff > FR_BITS'(ROW_LIMIT)) begin
			h_eff = FR_BITS'(ROW_LIMIT);
		end
		row_end   = CMP_W'(col_cur) >= (w_eff - CMP_W'(1));
		frame_end = row_end && (FR_BITS'(row_count_q) >= (h_eff - FR_BITS'(1)));
		win_now   = (row_count_q >= ROW_BITS'(WINDOW - 1))
			&& (col_cur >= COL_W'(WINDOW - 1));
	end

	// row and column counters advance on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (in_fire) begin
			if (row_end) begin
				col_count_q <= '0;
				row_count_q <= frame_end ? '0 : row_count_q + 1'b1;
			end else begin
				col_count_q <= col_cur + 1'b1;
			end
		end
	end

	// sum stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// sum stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			win_s1    <= win_now;
			last_s1   <= frame_end;
			sample_s1 <= sample;
			col_s1    <= col_cur;
			wrow_s1   <= row_count_q - ROW_BITS'(WINDOW - 1);
			wcol_s1   <= col_cur - COL_W'(WINDOW - 1);
		end
	end

	// line buffers: every row shifts up one place at its column
	for (genvar g = 0; g < WINDOW - 1; g++) begin : g_lb_shift
		if (g < WINDOW - 2) begin : g_up
			assign lb_wdata[g*SW +: SW] = lb_rdata[(g+1)*SW +: SW];
		end else begin : g_new
			assign lb_wdata[g*SW +: SW] = sample_s1;
		end
	end

	ws3_ram #(
		.WIDTH(LB_W),
		.DEPTH(MAX_COLS)
	) u_ws3_ram (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata (lb_wdata),
		.re    (in_fire),
		.raddr (col_cur),
		.rdata (lb_rdata)
	);

	// current column: buffered rows above, new sample at the bottom
	always_comb begin
		for (int j = 0; j < WINDOW - 1; j++) begin
			col_now[j] = lb_rdata[j*SW +: SW];
		end
		col_now[WINDOW-1] = sample_s1;
	end

	// adder tree over the whole window
	always_comb begin
		acc = '0;
		for (int i = 0; i < WINDOW - 1; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				acc = acc + ACC_W'(wcols_q[i][j]);
			end
		end
		for (int j = 0; j < WINDOW; j++) begin
			acc = acc + ACC_W'(col_now[j]);
		end
	end

	// window columns shift left, current column enters last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				for (int j = 0; j < WINDOW; j++) begin
					wcols_q[i][j] <= '0;
				end
			end
		end else if (s1_go) begin
			for (int i = 0; i < WINDOW - 2; i++) begin
				for (int j = 0; j < WINDOW; j++) begin
					wcols_q[i][j] <= wcols_q[i+1][j];
				end
			end
			for (int j = 0; j < WINDOW; j++) begin
				wcols_q[WINDOW-2][j] <= col_now[j];
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && win_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_go && win_s1) begin
			sum_q  <= acc[SUM_BITS-1:0];
			row_q  <= wrow_s1;
			col_q  <= wcol_s1;
			last_q <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_sum    = sum_q;
	assign window_row    = row_q;
	assign window_col    = col_q;
	assign last_of_frame = last_q;

endmodule

[rtl/ws3_checker.sv]
// port-level checks of the window sum block and their bind
`include "window_sum_3x3_assert.svh"

module ws3_checker #(
	parameter int MAX_COLS     = 64,
	parameter int SAMPLE_WIDTH = 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic signed [SAMPLE_WIDTH-1:0] sample,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [ws3_pkg::SUM_BITS-1:0] window_sum,
	input logic [ws3_pkg::ROW_BITS-1:0]  window_row,
	input logic [$clog2(MAX_COLS)-1:0]   window_col,
	input logic                          last_of_frame
);

	import ws3_pkg::*;

	localparam int COL_W = $clog2(MAX_COLS);

	logic                out_fire;
	logic                prev_valid_q;
	logic [ROW_BITS-1:0] prev_row_q;
	logic [COL_W-1:0]    prev_col_q;
	logic                prev_last_q;

	assign out_fire = out_valid && out_ready;

	// position of the last delivered window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_row_q   <= '0;
			prev_col_q   <= '0;
			prev_last_q  <= 1'b0;
		end else if (out_fire) begin
			prev_valid_q <= 1'b1;
			prev_row_q   <= window_row;
			prev_col_q   <= window_col;
			prev_last_q  <= last_of_frame;
		end
	end

	// a waiting request keeps its sample
	`WS3_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(sample),
		"waiting request dropped or changed")

	// a stalled result stays with its payload
	`WS3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(window_sum) && $stable(window_row)
		&& $stable(window_col) && $stable(last_of_frame),
		"stalled result changed")

	// inside a row, windows come at consecutive columns
	`WS3_ASSERT_NOW(a_col_step, out_fire && prev_valid_q && (window_col != '0),
		(window_col == COL_W'(prev_col_q + 1'b1)) && (window_row == prev_row_q),
		"window column skipped or row changed mid-row")

	// a new row of windows follows the previous row or opens a new frame
	`WS3_ASSERT_NOW(a_row_step, out_fire && prev_valid_q && (window_col == '0),
		(prev_last_q && (window_row == '0))
		|| (!prev_last_q && (window_row == ROW_BITS'(prev_row_q + 1'b1))),
		"window row out of sequence")

endmodule

bind window_sum_3x3 ws3_checker #(
	.MAX_COLS     (MAX_COLS),
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ws3_checker (.*);
